>>> rtl/ibc_pkg.sv
// ----------------------------------------------------------------------------
// ibc_pkg
// Shared widths, region, function and status codes and block map geometry for the
// inode block cursor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ibc_pkg;

    // block map geometry
    localparam int BLOCK_BYTES    = 512;
    localparam int PTRS_PER_BLOCK = 128;
    localparam int DIRECT_COUNT   = 10;
    localparam int SINGLE_COUNT   = 4;

    // field widths
    localparam int POS_W    = 31;
    localparam int REGION_W = 2;
    localparam int TOP_W    = 4;
    localparam int IDX_W    = $clog2(PTRS_PER_BLOCK);
    localparam int OFF_W    = $clog2(BLOCK_BYTES);

    // region boundaries in bytes
    localparam logic [POS_W:0] SPAN_PTR1  = (POS_W+1)'(BLOCK_BYTES * PTRS_PER_BLOCK);
    localparam logic [POS_W:0] SPAN_PTR2  = SPAN_PTR1 * PTRS_PER_BLOCK;
    localparam logic [POS_W:0] END_DIRECT = (POS_W+1)'(DIRECT_COUNT * BLOCK_BYTES);
    localparam logic [POS_W:0] END_SINGLE = END_DIRECT + SPAN_PTR1 * SINGLE_COUNT;
    localparam logic [POS_W:0] END_DOUBLE = END_SINGLE + SPAN_PTR2;
    localparam logic [POS_W:0] END_TRIPLE = END_DOUBLE + SPAN_PTR2 * PTRS_PER_BLOCK;

    localparam logic [TOP_W-1:0] DIRECT_LAST = TOP_W'(DIRECT_COUNT - 1);
    localparam logic [TOP_W-1:0] SINGLE_LAST = TOP_W'(SINGLE_COUNT - 1);
    localparam logic [IDX_W-1:0] PTR_LAST    = IDX_W'(PTRS_PER_BLOCK - 1);

    // function codes
    localparam logic FUNC_SEEK    = 1'b0;
    localparam logic FUNC_ADVANCE = 1'b1;

    // status codes
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    // region codes
    typedef logic [REGION_W-1:0] region_t;
    localparam region_t REGION_DIRECT = 2'd0;
    localparam region_t REGION_SINGLE = 2'd1;
    localparam region_t REGION_DOUBLE = 2'd2;
    localparam region_t REGION_TRIPLE = 2'd3;

endpackage

>>> rtl/inode_block_cursor.sv
// ----------------------------------------------------------------------------
// inode_block_cursor
// Cursor into an inode block map with direct, single, double and triple
// indirect regions: seek to a byte position or advance to the next block.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one word per request: s_func selects seek or advance,
//   s_byte_pos and s_file_size are used by seek only. m_ channel returns one
//   word per request: status, the cursor (region, four indices, byte offset)
//   after the request, and the linear byte position the cursor denotes.
//   A word accepted on the s_ channel sits in the input register; the cursor
//   update writes the result register once it is free, and m_valid is set.
//   Throughput is one word per cycle while m_ready is high; the cursor update
//   is a region compare, one 31-bit subtract and a short carry over the
//   indices, all combinational between the input register and the
//   cursor/result register.
//   The result register is the cursor itself, so the input register keeps
//   taking a word while a result waits; when m_ready is low both registers
//   fill and s_ready drops until the result is taken.
//   Synchronous active-low reset empties both registers and puts the cursor
//   at byte 0 of the direct region.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module inode_block_cursor (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_func,
    input  logic [ibc_pkg::POS_W-1:0]       s_byte_pos,
    input  logic [ibc_pkg::POS_W-1:0]       s_file_size,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_status,
    output logic [ibc_pkg::REGION_W-1:0]    m_region,
    output logic [ibc_pkg::TOP_W-1:0]       m_index_top,
    output logic [ibc_pkg::IDX_W-1:0]       m_index_second,
    output logic [ibc_pkg::IDX_W-1:0]       m_index_third,
    output logic [ibc_pkg::IDX_W-1:0]       m_index_fourth,
    output logic [ibc_pkg::OFF_W-1:0]       m_byte_offset,
    output logic [ibc_pkg::POS_W-1:0]       m_linear_pos
);

    localparam int POS_W = ibc_pkg::POS_W;
    localparam int TOP_W = ibc_pkg::TOP_W;
    localparam int IDX_W = ibc_pkg::IDX_W;
    localparam int OFF_W = ibc_pkg::OFF_W;
    localparam int BLK_W = POS_W - OFF_W;

    // input register
    logic                  in_valid_reg;
    logic                  in_func_reg;
    logic [POS_W-1:0]      in_pos_reg;
    logic [POS_W-1:0]      in_size_reg;

    // cursor, doubles as the result register
    logic                  m_valid_reg;
    logic                  status_reg;
    ibc_pkg::region_t      cur_region_reg, cur_region_next;
    logic [TOP_W-1:0]      cur_top_reg, cur_top_next;
    logic [IDX_W-1:0]      cur_second_reg, cur_second_next;
    logic [IDX_W-1:0]      cur_third_reg, cur_third_next;
    logic [IDX_W-1:0]      cur_fourth_reg, cur_fourth_next;
    logic [OFF_W-1:0]      cur_offset_reg, cur_offset_next;
    logic [POS_W-1:0]      lin_reg, lin_next;

    logic                  xfer;
    logic                  op_ok;

    // seek decode
    logic [POS_W:0]        pos_ext;
    logic [POS_W:0]        seek_base;
    logic [POS_W-1:0]      seek_d;
    logic                  seek_ok;
    ibc_pkg::region_t      seek_region;
    logic [TOP_W-1:0]      seek_top;
    logic [IDX_W-1:0]      seek_second, seek_third, seek_fourth;

    // advance
    logic                  adv_ok;
    ibc_pkg::region_t      adv_region;
    logic [TOP_W-1:0]      adv_top;
    logic [IDX_W-1:0]      adv_second, adv_third, adv_fourth;
    logic [POS_W-1:0]      adv_lin;

    assign xfer    = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || xfer;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_func_reg <= s_func;
            in_pos_reg  <= s_byte_pos;
            in_size_reg <= s_file_size;
        end
    end

    // seek: region by range compare, indices are bit slices of the offset
    always_comb begin
        pos_ext = {1'b0, in_pos_reg};
        seek_ok = (in_pos_reg <= in_size_reg) && (pos_ext < ibc_pkg::END_TRIPLE);
        if (pos_ext < ibc_pkg::END_DIRECT) begin
            seek_region = ibc_pkg::REGION_DIRECT;
            seek_base   = '0;
        end else if (pos_ext < ibc_pkg::END_SINGLE) begin
            seek_region = ibc_pkg::REGION_SINGLE;
            seek_base   = ibc_pkg::END_DIRECT;
        end else if (pos_ext < ibc_pkg::END_DOUBLE) begin
            seek_region = ibc_pkg::REGION_DOUBLE;
            seek_base   = ibc_pkg::END_SINGLE;
        end else begin
            seek_region = ibc_pkg::REGION_TRIPLE;
            seek_base   = ibc_pkg::END_DOUBLE;
        end
        seek_d      = in_pos_reg - seek_base[POS_W-1:0];
        seek_top    = '0;
        seek_second = '0;
        seek_third  = '0;
        seek_fourth = '0;
        case (seek_region)
            ibc_pkg::REGION_DIRECT: begin
                seek_top = seek_d[OFF_W +: TOP_W];
            end
            ibc_pkg::REGION_SINGLE: begin
                seek_top    = seek_d[OFF_W+IDX_W +: TOP_W];
                seek_second = seek_d[OFF_W +: IDX_W];
            end
            ibc_pkg::REGION_DOUBLE: begin
                seek_second = seek_d[OFF_W+IDX_W +: IDX_W];
                seek_third  = seek_d[OFF_W +: IDX_W];
            end
            default: begin
                seek_second = seek_d[OFF_W+2*IDX_W +: IDX_W];
                seek_third  = seek_d[OFF_W+IDX_W +: IDX_W];
                seek_fourth = seek_d[OFF_W +: IDX_W];
            end
        endcase
    end

    // advance: carry through the indices of the current region
    always_comb begin
        adv_ok     = 1'b1;
        adv_region = cur_region_reg;
        adv_top    = cur_top_reg;
        adv_second = cur_second_reg;
        adv_third  = cur_third_reg;
        adv_fourth = cur_fourth_reg;
        case (cur_region_reg)
            ibc_pkg::REGION_DIRECT: begin
                if (cur_top_reg >= ibc_pkg::DIRECT_LAST) begin
                    adv_region = ibc_pkg::REGION_SINGLE;
                    adv_top    = '0;
                    adv_second = '0;
                end else begin
                    adv_top = cur_top_reg + 1'b1;
                end
            end
            ibc_pkg::REGION_SINGLE: begin
                if (cur_second_reg >= ibc_pkg::PTR_LAST) begin
                    adv_second = '0;
                    if (cur_top_reg >= ibc_pkg::SINGLE_LAST) begin
                        adv_region = ibc_pkg::REGION_DOUBLE;
                        adv_top    = '0;
                        adv_third  = '0;
                    end else begin
                        adv_top = cur_top_reg + 1'b1;
                    end
                end else begin
                    adv_second = cur_second_reg + 1'b1;
                end
            end
            ibc_pkg::REGION_DOUBLE: begin
                if (cur_third_reg >= ibc_pkg::PTR_LAST) begin
                    adv_third = '0;
                    if (cur_second_reg >= ibc_pkg::PTR_LAST) begin
                        adv_region = ibc_pkg::REGION_TRIPLE;
                        adv_second = '0;
                        adv_fourth = '0;
                    end else begin
                        adv_second = cur_second_reg + 1'b1;
                    end
                end else begin
                    adv_third = cur_third_reg + 1'b1;
                end
            end
            default: begin
                if (cur_fourth_reg >= ibc_pkg::PTR_LAST) begin
                    if (cur_third_reg >= ibc_pkg::PTR_LAST) begin
                        if (cur_second_reg >= ibc_pkg::PTR_LAST) begin
                            adv_ok = 1'b0;
                        end else begin
                            adv_second = cur_second_reg + 1'b1;
                            adv_third  = '0;
                            adv_fourth = '0;
                        end
                    end else begin
                        adv_third  = cur_third_reg + 1'b1;
                        adv_fourth = '0;
                    end
                end else begin
                    adv_fourth = cur_fourth_reg + 1'b1;
                end
            end
        endcase
        // regions are contiguous, so the next block starts one block further on
        adv_lin = {lin_reg[POS_W-1:OFF_W] + BLK_W'(1), {OFF_W{1'b0}}};
    end

    assign op_ok = (in_func_reg == ibc_pkg::FUNC_ADVANCE) ? adv_ok : seek_ok;

    always_comb begin
        cur_region_next = cur_region_reg;
        cur_top_next    = cur_top_reg;
        cur_second_next = cur_second_reg;
        cur_third_next  = cur_third_reg;
        cur_fourth_next = cur_fourth_reg;
        cur_offset_next = cur_offset_reg;
        lin_next        = lin_reg;
        if (xfer && op_ok) begin
            if (in_func_reg == ibc_pkg::FUNC_ADVANCE) begin
                cur_region_next = adv_region;
                cur_top_next    = adv_top;
                cur_second_next = adv_second;
                cur_third_next  = adv_third;
                cur_fourth_next = adv_fourth;
                cur_offset_next = '0;
                lin_next        = adv_lin;
            end else begin
                cur_region_next = seek_region;
                cur_top_next    = seek_top;
                cur_second_next = seek_second;
                cur_third_next  = seek_third;
                cur_fourth_next = seek_fourth;
                cur_offset_next = in_pos_reg[OFF_W-1:0];
                lin_next        = in_pos_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            status_reg     <= ibc_pkg::STATUS_OK;
            cur_region_reg <= ibc_pkg::REGION_DIRECT;
            cur_top_reg    <= '0;
            cur_second_reg <= '0;
            cur_third_reg  <= '0;
            cur_fourth_reg <= '0;
            cur_offset_reg <= '0;
            lin_reg        <= '0;
        end else begin
            m_valid_reg    <= xfer || (m_valid_reg && !m_ready);
            if (xfer) begin
                status_reg <= op_ok ? ibc_pkg::STATUS_OK : ibc_pkg::STATUS_RANGE;
            end
            cur_region_reg <= cur_region_next;
            cur_top_reg    <= cur_top_next;
            cur_second_reg <= cur_second_next;
            cur_third_reg  <= cur_third_next;
            cur_fourth_reg <= cur_fourth_next;
            cur_offset_reg <= cur_offset_next;
            lin_reg        <= lin_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_region       = cur_region_reg;
    assign m_index_top    = cur_top_reg;
    assign m_index_second = cur_second_reg;
    assign m_index_third  = cur_third_reg;
    assign m_index_fourth = cur_fourth_reg;
    assign m_byte_offset  = cur_offset_reg;
    assign m_linear_pos   = lin_reg;

    // tracked linear position agrees with the cursor byte offset
    a_lin_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        lin_reg[OFF_W-1:0] == cur_offset_reg)
        else $error("linear position out of step with byte offset");

    // a rejected word leaves the cursor where it was
    a_reject_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (xfer && !op_ok) |=> ($stable(cur_region_reg) && $stable(lin_reg)
                              && $stable(cur_offset_reg) && $stable(cur_fourth_reg)))
        else $error("cursor moved on a rejected word");

    // an accepted advance lands on the start of a block
    a_adv_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        (xfer && op_ok && in_func_reg == ibc_pkg::FUNC_ADVANCE)
            |=> (cur_offset_reg == '0 && status_reg == ibc_pkg::STATUS_OK))
        else $error("advance did not clear byte offset");

    // top index is unused in the double and triple regions
    a_top_unused: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_region_reg == ibc_pkg::REGION_DOUBLE || cur_region_reg == ibc_pkg::REGION_TRIPLE)
            |-> cur_top_reg == '0)
        else $error("top index set outside direct and single regions");

    // a word in the input register reaches the result register when it is free
    a_result_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !m_valid_reg) |=> m_valid_reg)
        else $error("result register not loaded");

endmodule
